>>> src/big5tcl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Big5 text cursor layout block.
// No dependencies; imported by the core and the output buffer.
package big5tcl_pkg;

    localparam int CoordW  = 13;
    localparam int IndexW  = 16;
    localparam int CodeW   = 8;
    localparam int AdvW    = 8;
    localparam int CfgDatW = 13;
    localparam int CfgIdxW = 3;

    localparam logic [CodeW-1:0] CHAR_MIN     = 8'h1A;
    localparam logic [CodeW-1:0] CHAR_FIRST   = 8'h20;
    localparam logic [CodeW-1:0] CHAR_LAST    = 8'h7E;
    localparam logic [CodeW-1:0] CTRL_LIMIT   = 8'h20;
    localparam logic [8:0]       LEAD_BASE    = 9'h0A1;
    localparam logic [8:0]       ROW_SPAN     = 9'h09D;
    localparam logic [8:0]       LOW_HI_BASE  = 9'h062;
    localparam logic [8:0]       LOW_LO_BASE  = 9'h040;

    localparam logic [11:0] RST_WIN_LEFT  = 12'd0;
    localparam logic [11:0] RST_WIN_TOP   = 12'd0;
    localparam logic [12:0] RST_WIN_WIDTH = 13'd640;
    localparam logic [12:0] RST_WIN_HEIGHT = 13'd480;
    localparam logic [6:0]  RST_SGL_WIDTH = 7'd6;
    localparam logic [6:0]  RST_DBL_WIDTH = 7'd12;
    localparam logic [5:0]  RST_CHAR_GAP  = 6'd0;
    localparam logic [6:0]  RST_LINE_STEP = 7'd8;

    typedef enum logic [CfgIdxW-1:0] {
        REG_WIN_LEFT   = 3'd0,
        REG_WIN_TOP    = 3'd1,
        REG_WIN_WIDTH  = 3'd2,
        REG_WIN_HEIGHT = 3'd3,
        REG_SGL_WIDTH  = 3'd4,
        REG_DBL_WIDTH  = 3'd5,
        REG_CHAR_GAP   = 3'd6,
        REG_LINE_STEP  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic                     font_set;
        logic signed [IndexW-1:0] glyph_index;
        logic [CoordW-1:0]        pixel_x;
        logic [CoordW-1:0]        pixel_y;
    } glyph_t;

endpackage

>>> src/big5_text_cursor_layout_core.sv
`timescale 1ns / 1ps
// Top level of the Big5 text cursor layout block.
// Depends on big5tcl_pkg and big5tcl_out_buf.

// Lays out a text byte stream in a window: bytes 0x1A to 0x7E become
// single-byte glyphs (index byte - 0x20), other nonzero bytes pair with the
// next byte as a Big5 lead/low pair, and each drawn glyph comes out with its
// screen position.
// One byte is accepted per cycle while s_tready is high; the cursor update
// and glyph index for a byte are computed in the accept cycle, and the
// result is registered in the output buffer, whose two entries let input
// continue while a result waits; s_tready drops only while both are occupied.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wdata while
// the stream is idle; the user must keep to this, the block does not enforce it.
module big5_text_cursor_layout_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] glyph_index, [28:16] pixel_x, [41:29] pixel_y
    output logic        m_tuser,   // [0] font_set
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_wdata
);
    import big5tcl_pkg::*;

    logic [11:0] win_left_reg, win_top_reg;
    logic [12:0] win_width_reg, win_height_reg;
    logic [6:0]  sgl_width_reg, dbl_width_reg, line_step_reg;
    logic [5:0]  char_gap_reg;

    logic              lead_pending_reg, lead_pending_next;
    logic [CodeW-1:0]  lead_value_reg, lead_value_next;
    logic [CoordW-1:0] cursor_x_reg, cursor_x_next;
    logic [CoordW-1:0] cursor_y_reg, cursor_y_next;

    logic              accept;
    logic [CodeW-1:0]  code;
    logic              is_zero, is_char, do_wrap_check, wrap, emit;
    logic [AdvW-1:0]   advance;
    logic [CoordW:0]   x_sum, y_sum;
    logic [CoordW-1:0] cx_w, cy_w;
    logic              push;
    glyph_t            result;
    glyph_t            out_data;

    logic signed [8:0]  lead_off, low_off, char_off;
    logic signed [17:0] lead_ext, low_ext, prod, serial;

    assign accept  = s_tvalid & s_tready;
    assign code    = s_tdata;
    assign is_zero = (code == '0);
    assign is_char = (code >= CHAR_MIN) && (code <= CHAR_LAST);

    assign advance = lead_pending_reg ? ({1'b0, dbl_width_reg} + {2'b00, char_gap_reg})
                                      : ({1'b0, sgl_width_reg} + {2'b00, char_gap_reg});

    assign do_wrap_check = !is_zero && (lead_pending_reg || is_char);
    assign x_sum = {1'b0, cursor_x_reg} + {{(CoordW+1-AdvW){1'b0}}, advance};
    assign y_sum = {1'b0, cursor_y_reg} + {{(CoordW+1-7){1'b0}}, line_step_reg};
    assign wrap  = do_wrap_check && (x_sum >= {1'b0, win_width_reg});
    assign cx_w  = wrap ? '0 : cursor_x_reg;
    assign cy_w  = (wrap && (y_sum < {1'b0, win_height_reg})) ? y_sum[CoordW-1:0]
                                                               : cursor_y_reg;

    assign emit = !is_zero && (lead_pending_reg ? (lead_value_reg >= CTRL_LIMIT) : is_char);

    // single-byte index goes negative for bytes below 0x20
    assign char_off = $signed({1'b0, code}) - $signed({1'b0, CHAR_FIRST});

    // Big5 serial: (lead - 0xA1) * 0x9D + (low - 0x62 or 0x40)
    assign lead_off = $signed({1'b0, lead_value_reg}) - $signed(LEAD_BASE);
    assign low_off  = $signed({1'b0, code})
                    - $signed(code[7] ? LOW_HI_BASE : LOW_LO_BASE);
    assign lead_ext = {{9{lead_off[8]}}, lead_off};
    assign low_ext  = {{9{low_off[8]}}, low_off};
    assign prod     = lead_ext * $signed({9'd0, ROW_SPAN});
    assign serial   = prod + low_ext;

    always_comb begin
        result.font_set    = lead_pending_reg;
        result.glyph_index = lead_pending_reg ? serial[IndexW-1:0]
                                              : {{(IndexW-9){char_off[8]}}, char_off};
        result.pixel_x     = {1'b0, win_left_reg} + cx_w;
        result.pixel_y     = {1'b0, win_top_reg} + cy_w;
    end

    always_comb begin
        lead_pending_next = lead_pending_reg;
        lead_value_next   = lead_value_reg;
        cursor_x_next     = cursor_x_reg;
        cursor_y_next     = cursor_y_reg;
        if (accept) begin
            if (is_zero) begin
                lead_pending_next = 1'b0;
            end else if (lead_pending_reg || is_char) begin
                lead_pending_next = 1'b0;
                cursor_y_next     = cy_w;
                cursor_x_next     = emit ? (cx_w + {{(CoordW-AdvW){1'b0}}, advance}) : cx_w;
            end else begin
                lead_pending_next = 1'b1;
                lead_value_next   = code;
            end
        end
    end

    assign push = accept & emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_pending_reg <= 1'b0;
            lead_value_reg   <= '0;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
        end else begin
            lead_pending_reg <= lead_pending_next;
            lead_value_reg   <= lead_value_next;
            cursor_x_reg     <= cursor_x_next;
            cursor_y_reg     <= cursor_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_left_reg   <= RST_WIN_LEFT;
            win_top_reg    <= RST_WIN_TOP;
            win_width_reg  <= RST_WIN_WIDTH;
            win_height_reg <= RST_WIN_HEIGHT;
            sgl_width_reg  <= RST_SGL_WIDTH;
            dbl_width_reg  <= RST_DBL_WIDTH;
            char_gap_reg   <= RST_CHAR_GAP;
            line_step_reg  <= RST_LINE_STEP;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WIN_LEFT:   win_left_reg   <= cfg_wdata[11:0];
                REG_WIN_TOP:    win_top_reg    <= cfg_wdata[11:0];
                REG_WIN_WIDTH:  win_width_reg  <= cfg_wdata;
                REG_WIN_HEIGHT: win_height_reg <= cfg_wdata;
                REG_SGL_WIDTH:  sgl_width_reg  <= cfg_wdata[6:0];
                REG_DBL_WIDTH:  dbl_width_reg  <= cfg_wdata[6:0];
                REG_CHAR_GAP:   char_gap_reg   <= cfg_wdata[5:0];
                REG_LINE_STEP:  line_step_reg  <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    big5tcl_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (result),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_data    (out_data)
    );

    assign m_tuser = out_data.font_set;
    assign m_tdata = {6'd0, out_data.pixel_y, out_data.pixel_x, out_data.glyph_index};

endmodule

>>> src/big5tcl_out_buf.sv
`timescale 1ns / 1ps
// Two-entry output buffer (output register plus skid register) for glyph results.
// Depends on big5tcl_pkg.
module big5tcl_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  big5tcl_pkg::glyph_t  push_data,
    output logic                 in_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output big5tcl_pkg::glyph_t  m_data
);
    import big5tcl_pkg::*;

    logic   out_valid_reg, out_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    glyph_t out_reg, out_next;
    glyph_t skid_reg, skid_next;
    logic   pop;

    assign pop      = out_valid_reg & m_tready;
    assign in_ready = ~skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (pop || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = push_data;
                out_valid_next = push;
            end
        end else if (push) begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

>>> src/big5tcl_checker.sv
`timescale 1ns / 1ps
// Port-level checks for big5_text_cursor_layout_core, attached by bind.
// Depends only on the top level's ports.
module big5tcl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // single-byte index spans -6 to 94
    a_single_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[15:0] <= 16'd94) || (m_tdata[15:0] >= 16'hFFFA))
        else $error("single-byte glyph index out of range");

    a_zero_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata == 8'd0) && !m_tvalid |=> !m_tvalid)
        else $error("zero byte produced a result");

endmodule

bind big5_text_cursor_layout_core big5tcl_checker u_big5tcl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/tb_big5_text_cursor_layout_core.sv
`timescale 1ns / 1ps
// Testbench for big5_text_cursor_layout_core. It streams text bytes under
// several window settings and checks each glyph against a layout scoreboard.
// Depends on big5tcl_pkg and the RTL in src; needs no other files.
module tb_big5_text_cursor_layout_core;
    import big5tcl_pkg::*;

    class layout_scoreboard;
        logic [11:0] win_left, win_top;
        logic [12:0] win_width, win_height;
        logic [6:0]  sgl_width, dbl_width, line_step;
        logic [5:0]  char_gap;
        logic        lead_held;
        logic [7:0]  lead_byte;
        logic [12:0] cur_x, cur_y;
        glyph_t      glyphs_due[$];
        int          errors, glyphs_checked, bytes_taken;

        function new();
            win_left       = RST_WIN_LEFT;
            win_top        = RST_WIN_TOP;
            win_width      = RST_WIN_WIDTH;
            win_height     = RST_WIN_HEIGHT;
            sgl_width      = RST_SGL_WIDTH;
            dbl_width      = RST_DBL_WIDTH;
            char_gap       = RST_CHAR_GAP;
            line_step      = RST_LINE_STEP;
            lead_held      = 1'b0;
            lead_byte      = '0;
            cur_x          = '0;
            cur_y          = '0;
            errors         = 0;
            glyphs_checked = 0;
            bytes_taken    = 0;
        endfunction

        function void write_reg(cfg_reg_t r, logic [12:0] v);
            case (r)
                REG_WIN_LEFT:   win_left   = v[11:0];
                REG_WIN_TOP:    win_top    = v[11:0];
                REG_WIN_WIDTH:  win_width  = v;
                REG_WIN_HEIGHT: win_height = v;
                REG_SGL_WIDTH:  sgl_width  = v[6:0];
                REG_DBL_WIDTH:  dbl_width  = v[6:0];
                REG_CHAR_GAP:   char_gap   = v[5:0];
                REG_LINE_STEP:  line_step  = v[6:0];
                default: ;
            endcase
        endfunction

        // wrap before the character; no scroll at the bottom
        function void line_break(int adv);
            if (int'(cur_x) + adv >= int'(win_width)) begin
                cur_x = '0;
                if (int'(cur_y) + int'(line_step) < int'(win_height))
                    cur_y = cur_y + line_step;
            end
        endfunction

        function void place_glyph(logic font, int idx, int adv);
            glyph_t g;
            g.font_set    = font;
            g.glyph_index = idx[15:0];
            g.pixel_x     = win_left + cur_x;
            g.pixel_y     = win_top + cur_y;
            glyphs_due.push_back(g);
            cur_x = cur_x + adv[12:0];
        endfunction

        function void note_byte(logic [7:0] b);
            int adv, serial;
            bytes_taken++;
            if (b == '0) begin
                lead_held = 1'b0;
            end else if (lead_held) begin
                lead_held = 1'b0;
                adv = int'(dbl_width) + int'(char_gap);
                line_break(adv);
                if (lead_byte >= CTRL_LIMIT) begin
                    serial = (int'(lead_byte) - int'(LEAD_BASE)) * int'(ROW_SPAN) + int'(b)
                           - (b[7] ? int'(LOW_HI_BASE) : int'(LOW_LO_BASE));
                    place_glyph(1'b1, serial, adv);
                end
            end else if (b >= CHAR_MIN && b <= CHAR_LAST) begin
                adv = int'(sgl_width) + int'(char_gap);
                line_break(adv);
                place_glyph(1'b0, int'(b) - int'(CHAR_FIRST), adv);
            end else begin
                lead_held = 1'b1;
                lead_byte = b;
            end
        endfunction

        function void check_glyph(glyph_t got);
            glyph_t want;
            if (glyphs_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected glyph, expected none, actual %h", $time, got);
                return;
            end
            want = glyphs_due.pop_front();
            glyphs_checked++;
            if (got.font_set !== want.font_set) begin
                errors++;
                $display("%0t: font_set expected %0d actual %0d",
                         $time, want.font_set, got.font_set);
            end
            if (got.glyph_index !== want.glyph_index) begin
                errors++;
                $display("%0t: glyph_index expected %0d actual %0d",
                         $time, want.glyph_index, got.glyph_index);
            end
            if (got.pixel_x !== want.pixel_x) begin
                errors++;
                $display("%0t: pixel_x expected %0d actual %0d",
                         $time, want.pixel_x, got.pixel_x);
            end
            if (got.pixel_y !== want.pixel_y) begin
                errors++;
                $display("%0t: pixel_y expected %0d actual %0d",
                         $time, want.pixel_y, got.pixel_y);
            end
        endfunction
    endclass

    localparam int REG_MIN [8] = '{0, 0, 1, 1, 1, 1, 0, 1};
    localparam int REG_MAX [8] = '{4095, 4095, 4096, 4096, 64, 64, 63, 127};
    localparam int REG_MID [8] = '{4095, 4095, 300, 600, 64, 64, 8, 40};

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [12:0] cfg_wdata = '0;

    int send_idle_pct = 34;
    int recv_idle_pct = 80;
    int hold_asked    = 0;
    int hold_done     = 0;

    layout_scoreboard sb = new();

    big5_text_cursor_layout_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3ms;
        $display("tb: failure");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when asked
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_asked != hold_done) begin
                hold_done = hold_asked;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        glyph_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.font_set    = m_tuser;
            got.glyph_index = m_tdata[15:0];
            got.pixel_x     = m_tdata[28:16];
            got.pixel_y     = m_tdata[41:29];
            sb.check_glyph(got);
        end
    end

    // called and returns at a falling edge; leaves tvalid high
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b);
        @(negedge aclk);
    endtask

    task automatic program_window(input logic [12:0] vals [8]);
        for (int r = 0; r < 8; r++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= cfg_reg_t'(r);
            cfg_wdata <= vals[r];
            @(posedge aclk);
            sb.write_reg(cfg_reg_t'(r), vals[r]);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.glyphs_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        logic [7:0]  directed [25];
        logic [12:0] regs [8];
        logic [7:0]  lead, low;
        int          sent, kind, pick;

        directed = '{8'h20, 8'h7E, 8'h41, 8'h00, 8'hA4, 8'h40, 8'hA4, 8'hA1, 8'hFF,
                     8'hFF, 8'h7F, 8'h01, 8'h80, 8'h7F, 8'h01, 8'h41, 8'h1F, 8'hFE,
                     8'hC6, 8'h00, 8'h19, 8'h20, 8'h85, 8'h7E, 8'h00};

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: edge codes, control pairs, dropped leads
        for (int i = 0; i < 25; i++)
            send_byte(directed[i]);

        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            for (int r = 0; r < 8; r++) begin
                pick = (phase == 0) ? 0 : (phase == 1) ? 1 : $urandom_range(3);
                if (pick == 0)
                    regs[r] = 13'(REG_MIN[r]);
                else if (pick == 1)
                    regs[r] = 13'(REG_MAX[r]);
                else
                    regs[r] = 13'($urandom_range(REG_MID[r], REG_MIN[r]));
            end
            program_window(regs);

            if (phase == 3) begin
                send_idle_pct = 80;
                recv_idle_pct = 34;
            end
            if (phase == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_asked++;
            end

            sent = 0;
            while (sent < 100) begin
                kind = $urandom_range(99);
                if (kind < 50) begin
                    send_byte(8'($urandom_range(8'h7E, 8'h20)));
                    sent++;
                end else if (kind < 85) begin
                    lead = 8'($urandom_range(8'hFE, 8'hA1));
                    if ($urandom_range(3) == 0)
                        lead = 8'($urandom_range(8'hFF, 8'h7F));
                    low = $urandom_range(1) ? 8'($urandom_range(8'h7E, 8'h40))
                                            : 8'($urandom_range(8'hFE, 8'hA1));
                    if ($urandom_range(4) == 0)
                        low = 8'($urandom_range(8'hFF, 8'h01));
                    send_byte(lead);
                    send_byte(low);
                    sent += 2;
                end else if (kind < 90) begin
                    send_byte(8'($urandom_range(8'h1F, 8'h01)));
                    send_byte(8'($urandom_range(8'hFF, 8'h01)));
                    sent += 2;
                end else if (kind < 95) begin
                    send_byte('0);
                end else begin
                    send_byte(8'($urandom));
                    sent++;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (sb.glyphs_due.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);

        $display("summary: %0d bytes accepted, %0d glyphs checked, %0d mismatches",
                 sb.bytes_taken, sb.glyphs_checked, sb.errors);
        $display("summary: reset plus 8 window settings incl. min/max, stalls and backpressure");
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
src/big5tcl_pkg.sv
src/big5tcl_out_buf.sv
src/big5_text_cursor_layout_core.sv
src/big5tcl_checker.sv
test/tb_big5_text_cursor_layout_core.sv
